FILE: rtl/reliable_send_retransmit_queue_defines.svh
// assertion macros used by the rtl
`ifndef RELIABLE_SEND_RETRANSMIT_QUEUE_DEFINES_SVH
`define RELIABLE_SEND_RETRANSMIT_QUEUE_DEFINES_SVH

// same-cycle implication
`define RSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsq assertion failed");

// next-cycle implication
`define RSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsq assertion failed");

`endif

FILE: rtl/rsq_pkg.sv
package rsq_pkg;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned AW        = 10;
  localparam int unsigned CW        = 11;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned BW        = 7;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_FLUSH = 3'd1;
  localparam logic [2:0] CMD_ACK   = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_RETRY = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  localparam logic [2:0] TYPE_PING     = 3'd2;
  localparam logic [2:0] TYPE_RESET    = 3'd3;
  localparam logic [2:0] TYPE_SHUTDOWN = 3'd4;

  localparam logic [1:0] KIND_PKT    = 2'd0;
  localparam logic [1:0] KIND_SPAN   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_URGENT_THR  = 2'd1;
  localparam logic [1:0] REG_BURST_LIMIT = 2'd2;

  typedef struct packed {
    logic [31:0] seq;
    logic [2:0]  kind;
    logic [31:0] stamp;
    logic [31:0] body;
  } entry_t;

endpackage

FILE: rtl/rsq_if.sv
interface rsq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [2:0]  msg_type;
  logic [31:0] payload;
  logic [31:0] ack_seq;
  logic [31:0] ack_expect;
  logic [31:0] now_time;
  modport source (output valid, cmd, msg_type, payload, ack_seq, ack_expect, now_time,
                  input ready);
  modport sink (input valid, cmd, msg_type, payload, ack_seq, ack_expect, now_time,
                output ready);
endinterface

interface rsq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seq_id;
  logic [2:0]  pkt_type;
  logic [31:0] send_time;
  logic [31:0] pkt_payload;
  logic [31:0] block_begin;
  logic [31:0] block_end;
  logic [31:0] block_age;
  logic [10:0] queue_count;
  logic        reset_done;
  logic        urgent_flag;
  logic        last;
  modport source (output valid, kind, seq_id, pkt_type, send_time, pkt_payload,
                  block_begin, block_end, block_age, queue_count, reset_done,
                  urgent_flag, last, input ready);
  modport sink (input valid, kind, seq_id, pkt_type, send_time, pkt_payload,
                block_begin, block_end, block_age, queue_count, reset_done,
                urgent_flag, last, output ready);
endinterface

FILE: rtl/rsq_ram.sv
module rsq_ram #(
  parameter int unsigned DW = 8,
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/reliable_send_retransmit_queue.sv
// retransmit queue for a reliable sender
// requests enter on in_i (valid/ready) one at a time; ready is high only while idle
// each request gives one or more result items on out_o, the final one marked by last
// push, ack on the fast path, reset, and unknown commands go from the exec step straight to the emit step
// retry and query read the entry memory: retry reads the head entry, query the head and then the tail entry
// flush sends its packets one after another, each as a memory read then an output load
// a cumulative ack drops one entry per cycle through the single read port
// results sit in one output register; a stalled receiver holds the sequencer
// in its emit step and no new request is taken until the last item is loaded
// reset clears pointers, count, sequence counter and flags; entry memory is
// left as is and only entries held in the queue are ever read
// configuration is on the apb port: max_entries at 0x0, urgent_threshold at 0x4,
// burst_limit at 0x8; write them only while the block is idle
module reliable_send_retransmit_queue import rsq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsq_in_if.sink       in_i,
  rsq_out_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  `include "reliable_send_retransmit_queue_defines.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_FLUSH = 4'd2;
  localparam logic [3:0] S_ACK   = 4'd3;
  localparam logic [3:0] S_RETRY = 4'd4;
  localparam logic [3:0] S_QHEAD = 4'd5;
  localparam logic [3:0] S_QTAIL = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  logic [3:0]    state_q, state_d;
  logic [2:0]    cmd_q, type_q;
  logic [31:0]   body_q, aseq_q, exp_q, now_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d, uo_q, uo_d;
  logic [31:0]   lseq_q, lseq_d;
  logic          racked_q, racked_d, urg_q, urg_d;
  logic [BW-1:0] lim_q, lim_d, n_q, n_d;
  logic          first_q, first_d, erased_q, erased_d;
  logic [31:0]   bbeg_q, bbeg_d, bstamp_q, bstamp_d;
  logic [CW-1:0] max_q, thr_q;
  logic [BW-1:0] burst_q;

  logic [1:0]    hk_q, hk_d;
  logic [31:0]   hseq_q, hseq_d, hstamp_q, hstamp_d, hbody_q, hbody_d;
  logic [2:0]    htype_q, htype_d;
  logic [31:0]   hbeg_q, hbeg_d, hend_q, hend_d, hage_q, hage_d;
  logic          hlast_q, hlast_d;

  logic          ov_q, ov_d, load;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  logic [CW-1:0] cap;
  logic [BW-1:0] burst_eff;
  logic          cfg_wr;

  assign cap       = (max_q == '0) ? CW'(1) : ((max_q > CW'(DEPTH)) ? CW'(DEPTH) : max_q);
  assign burst_eff = (burst_q == '0) ? BW'(1)
                   : ((burst_q > BW'(MAX_BURST)) ? BW'(MAX_BURST) : burst_q);

  rsq_ram #(.DW($bits(entry_t)), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign load       = (state_q == S_EMIT) && (!ov_q || out_o.ready);

  always_comb begin
    logic [CW-1:0] c;
    logic [CW-1:0] u;
    logic [AW-1:0] hd;
    logic          g;
    logic          e;
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    uo_d     = uo_q;
    lseq_d   = lseq_q;
    racked_d = racked_q;
    urg_d    = urg_q;
    lim_d    = lim_q;
    n_d      = n_q;
    first_d  = first_q;
    erased_d = erased_q;
    bbeg_d   = bbeg_q;
    bstamp_d = bstamp_q;
    hk_d     = hk_q;
    hseq_d   = hseq_q;
    htype_d  = htype_q;
    hstamp_d = hstamp_q;
    hbody_d  = hbody_q;
    hbeg_d   = hbeg_q;
    hend_d   = hend_q;
    hage_d   = hage_q;
    hlast_d  = hlast_q;
    we       = 1'b0;
    waddr    = head_q;
    wdata    = '0;
    re       = 1'b0;
    raddr    = head_q;
    c        = cnt_q;
    u        = uo_q;
    hd       = head_q;
    g        = urg_q;
    e        = erased_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // status item unless overwritten below
        hk_d     = KIND_STATUS;
        hseq_d   = '0;
        htype_d  = '0;
        hstamp_d = '0;
        hbody_d  = '0;
        hbeg_d   = '0;
        hend_d   = '0;
        hage_d   = '0;
        hlast_d  = 1'b1;
        state_d  = S_EMIT;
        case (cmd_q)
          CMD_PUSH: begin
            lseq_d = lseq_q + 32'd1;
            if (cnt_q > thr_q) begin
              urg_d = 1'b1;
            end
            if (cnt_q >= cap) begin
              hd = head_q + AW'(1);
              c  = cnt_q - CW'(1);
              u  = (uo_q != '0) ? uo_q - CW'(1) : uo_q;
            end
            we     = 1'b1;
            waddr  = hd + c[AW-1:0];
            wdata  = '{seq: lseq_q + 32'd1, kind: type_q, stamp: now_q, body: body_q};
            head_d = hd;
            cnt_d  = c + CW'(1);
            uo_d   = u;
          end
          CMD_FLUSH: begin
            if (racked_q && (uo_q < cnt_q)) begin
              g = urg_q;
              if (cnt_q > thr_q) begin
                g = 1'b1;
              end
              urg_d   = g;
              lim_d   = g ? BW'(1) : burst_eff;
              n_d     = '0;
              re      = 1'b1;
              raddr   = head_q + uo_q[AW-1:0];
              state_d = S_FLUSH;
            end
          end
          CMD_ACK: begin
            if (type_q == TYPE_SHUTDOWN) begin
              racked_d = 1'b0;
            end else if ((type_q != TYPE_PING) && (cnt_q != '0)) begin
              re       = 1'b1;
              first_d  = 1'b1;
              erased_d = 1'b0;
              state_d  = S_ACK;
            end
          end
          CMD_RESET: begin
            racked_d = 1'b0;
            hk_d     = KIND_PKT;
            htype_d  = TYPE_RESET;
            hstamp_d = now_q;
            if (cnt_q < cap) begin
              head_d = head_q - AW'(1);
              we     = 1'b1;
              waddr  = head_q - AW'(1);
              wdata  = '{seq: 32'd0, kind: TYPE_RESET, stamp: now_q, body: 32'd0};
              cnt_d  = cnt_q + CW'(1);
              uo_d   = CW'(1);
            end else begin
              uo_d = '0;
            end
          end
          CMD_RETRY: begin
            if (cnt_q != '0) begin
              re      = 1'b1;
              state_d = S_RETRY;
            end
          end
          CMD_QUERY: begin
            if (cnt_q != '0) begin
              re      = 1'b1;
              state_d = S_QHEAD;
            end
          end
          default: begin
          end
        endcase
      end
      S_FLUSH: begin
        hk_d     = KIND_PKT;
        hseq_d   = rdata.seq;
        htype_d  = rdata.kind;
        hstamp_d = rdata.stamp;
        hbody_d  = rdata.body;
        hlast_d  = !(((uo_q + CW'(1)) < cnt_q) && ((n_q + BW'(1)) < lim_q));
        uo_d     = uo_q + CW'(1);
        n_d      = n_q + BW'(1);
        state_d  = S_EMIT;
      end
      S_ACK: begin
        state_d = S_EMIT;
        if ((exp_q != '0) && racked_q) begin
          if (first_q && (rdata.seq < aseq_q)) begin
            u = '0;
            g = 1'b1;
          end
          if (rdata.seq <= exp_q) begin
            hd = head_q + AW'(1);
            c  = cnt_q - CW'(1);
            u  = (u != '0) ? u - CW'(1) : u;
            e  = 1'b1;
          end
          if ((rdata.seq <= exp_q) && (c != '0)) begin
            re      = 1'b1;
            raddr   = hd;
            first_d = 1'b0;
            state_d = S_ACK;
          end else if (g && ((c == '0) || e)) begin
            if (c == '0) begin
              g = 1'b0;
            end
            u = '0;
          end
        end else begin
          if (rdata.seq < aseq_q) begin
            u = '0;
            g = 1'b1;
          end else if ((rdata.seq == aseq_q) && (rdata.kind == type_q)) begin
            hd = head_q + AW'(1);
            c  = cnt_q - CW'(1);
            u  = (uo_q != '0) ? uo_q - CW'(1) : uo_q;
            if (type_q == TYPE_RESET) begin
              racked_d = 1'b1;
            end
            if (c == '0) begin
              g = 1'b0;
            end
          end
        end
        head_d   = hd;
        cnt_d    = c;
        uo_d     = u;
        urg_d    = g;
        erased_d = e;
      end
      S_RETRY: begin
        hk_d     = KIND_PKT;
        hseq_d   = rdata.seq;
        htype_d  = rdata.kind;
        hstamp_d = rdata.stamp;
        hbody_d  = rdata.body;
        state_d  = S_EMIT;
      end
      S_QHEAD: begin
        bbeg_d   = rdata.seq;
        bstamp_d = rdata.stamp;
        re       = 1'b1;
        raddr    = head_q + AW'(cnt_q - CW'(1));
        state_d  = S_QTAIL;
      end
      S_QTAIL: begin
        hk_d    = KIND_SPAN;
        hbeg_d  = bbeg_q;
        hend_d  = rdata.seq;
        hage_d  = now_q - bstamp_q;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          if (hlast_q) begin
            state_d = S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = head_q + uo_q[AW-1:0];
            state_d = S_FLUSH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q && !out_o.ready;
    if (load) begin
      ov_d = 1'b1;
    end
  end

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_MAX_ENTRIES: prdata = 32'(max_q);
      REG_URGENT_THR:  prdata = 32'(thr_q);
      REG_BURST_LIMIT: prdata = 32'(burst_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      uo_q     <= '0;
      lseq_q   <= '0;
      racked_q <= 1'b0;
      urg_q    <= 1'b0;
      lim_q    <= '0;
      n_q      <= '0;
      first_q  <= 1'b0;
      erased_q <= 1'b0;
      hlast_q  <= 1'b0;
      ov_q     <= 1'b0;
      max_q    <= CW'(DEPTH);
      thr_q    <= CW'(DEPTH - 1);
      burst_q  <= BW'(MAX_BURST);
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      uo_q     <= uo_d;
      lseq_q   <= lseq_d;
      racked_q <= racked_d;
      urg_q    <= urg_d;
      lim_q    <= lim_d;
      n_q      <= n_d;
      first_q  <= first_d;
      erased_q <= erased_d;
      hlast_q  <= hlast_d;
      ov_q     <= ov_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_MAX_ENTRIES: max_q   <= pwdata[CW-1:0];
          REG_URGENT_THR:  thr_q   <= pwdata[CW-1:0];
          REG_BURST_LIMIT: burst_q <= pwdata[BW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      type_q <= in_i.msg_type;
      body_q <= in_i.payload;
      aseq_q <= in_i.ack_seq;
      exp_q  <= in_i.ack_expect;
      now_q  <= in_i.now_time;
    end
    bbeg_q   <= bbeg_d;
    bstamp_q <= bstamp_d;
    hk_q     <= hk_d;
    hseq_q   <= hseq_d;
    htype_q  <= htype_d;
    hstamp_q <= hstamp_d;
    hbody_q  <= hbody_d;
    hbeg_q   <= hbeg_d;
    hend_q   <= hend_d;
    hage_q   <= hage_d;
    if (load) begin
      out_o.kind        <= hk_q;
      out_o.seq_id      <= hseq_q;
      out_o.pkt_type    <= htype_q;
      out_o.send_time   <= hstamp_q;
      out_o.pkt_payload <= hbody_q;
      out_o.block_begin <= hbeg_q;
      out_o.block_end   <= hend_q;
      out_o.block_age   <= hage_q;
      out_o.queue_count <= cnt_q;
      out_o.reset_done  <= racked_q;
      out_o.urgent_flag <= urg_q;
      out_o.last        <= hlast_q;
    end
  end

  assign out_o.valid = ov_q;

  `RSQ_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH))
  `RSQ_ASSERT_NOW(a_unsent_bound, clk_i, rst_ni, 1'b1, uo_q <= cnt_q)
  `RSQ_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, load && hlast_q, state_q == S_IDLE)
  `RSQ_ASSERT_NOW(a_flush_gated, clk_i, rst_ni, state_q == S_FLUSH, racked_q && (uo_q < cnt_q))

endmodule

FILE: tb/sv/reliable_send_retransmit_queue_tb.sv
`timescale 1ns / 1ps

module reliable_send_retransmit_queue_tb import rsq_pkg::*;;

  localparam int unsigned WD_LIMIT = 20000;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  msg_type;
    logic [31:0] payload;
    logic [31:0] ack_seq;
    logic [31:0] ack_expect;
    logic [31:0] now_time;
  } req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq_id;
    logic [2:0]  pkt_type;
    logic [31:0] send_time;
    logic [31:0] pkt_payload;
    logic [31:0] block_begin;
    logic [31:0] block_end;
    logic [31:0] block_age;
    logic [10:0] queue_count;
    logic        reset_done;
    logic        urgent_flag;
    logic        last;
  } res_t;

  typedef struct {
    req_t        r;
    bit          chk;
    logic [1:0]  kind;
    logic [10:0] count;
    logic        rdone;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rsq_in_if  in_if ();
  rsq_out_if out_if ();

  reliable_send_retransmit_queue u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // queue shadow
  logic [31:0] q_seq [DEPTH];
  logic [2:0]  q_type [DEPTH];
  logic [31:0] q_stamp [DEPTH];
  logic [31:0] q_body [DEPTH];
  int unsigned q_head, q_cnt, q_unsent;
  logic [31:0] q_last_seq;
  bit          q_racked, q_urgent;
  int unsigned cfg_max, cfg_thr, cfg_burst;

  res_t        sent_q[$];
  res_t        first_pred;
  int          fails;
  int          src_idle, snk_stall;
  int unsigned wd_cnt;
  logic [31:0] clock_now;
  row_t        rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned slot(int unsigned off);
    return (q_head + off) % DEPTH;
  endfunction

  function automatic int unsigned capacity();
    int unsigned c;
    c = cfg_max;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void drop_head();
    q_head = slot(1);
    q_cnt--;
    if (q_unsent > 0) q_unsent--;
  endfunction

  function automatic res_t blank();
    res_t x;
    x = '{default: '0};
    return x;
  endfunction

  function automatic res_t packet_of(logic [31:0] s, logic [2:0] t, logic [31:0] st,
                                     logic [31:0] b);
    res_t x;
    x = blank();
    x.kind = KIND_PKT;
    x.seq_id = s;
    x.pkt_type = t;
    x.send_time = st;
    x.pkt_payload = b;
    return x;
  endfunction

  function automatic res_t entry_packet(int unsigned off);
    int unsigned s;
    s = slot(off);
    return packet_of(q_seq[s], q_type[s], q_stamp[s], q_body[s]);
  endfunction

  function automatic void apply_ack(logic [2:0] t, logic [31:0] aseq, logic [31:0] expct);
    int unsigned hs;
    bit erased;
    if (t == TYPE_PING) return;
    if (t == TYPE_SHUTDOWN) begin
      q_racked = 1'b0;
      return;
    end
    if (q_cnt == 0) return;
    hs = slot(0);
    if (expct != 0 && q_racked) begin
      erased = 1'b0;
      if (q_seq[hs] < aseq) begin
        q_unsent = 0;
        q_urgent = 1'b1;
      end
      while (q_cnt > 0 && q_seq[slot(0)] <= expct) begin
        drop_head();
        erased = 1'b1;
      end
      if (q_urgent && (q_cnt == 0 || erased)) begin
        if (q_cnt == 0) q_urgent = 1'b0;
        q_unsent = 0;
      end
    end else begin
      if (q_seq[hs] < aseq) begin
        q_unsent = 0;
        q_urgent = 1'b1;
      end else if (q_seq[hs] == aseq && q_type[hs] == t) begin
        drop_head();
        if (t == TYPE_RESET) q_racked = 1'b1;
        if (q_urgent && q_cnt == 0) q_urgent = 1'b0;
      end
    end
  endfunction

  function automatic void predict(req_t r);
    res_t items[$];
    res_t x;
    int unsigned s, lim;
    case (r.cmd)
      CMD_PUSH: begin
        q_last_seq = q_last_seq + 1;
        if (q_cnt > cfg_thr) q_urgent = 1'b1;
        if (q_cnt >= capacity()) drop_head();
        s = slot(q_cnt);
        q_seq[s] = q_last_seq;
        q_type[s] = r.msg_type;
        q_stamp[s] = r.now_time;
        q_body[s] = r.payload;
        q_cnt++;
      end
      CMD_FLUSH: begin
        if (q_racked && q_unsent < q_cnt) begin
          lim = cfg_burst;
          if (q_cnt > cfg_thr) q_urgent = 1'b1;
          if (lim == 0) lim = 1;
          if (lim > MAX_BURST) lim = MAX_BURST;
          if (q_urgent) lim = 1;
          while (q_unsent < q_cnt && items.size() < lim) begin
            items.push_back(entry_packet(q_unsent));
            q_unsent++;
          end
        end
      end
      CMD_ACK: apply_ack(r.msg_type, r.ack_seq, r.ack_expect);
      CMD_RESET: begin
        q_racked = 1'b0;
        items.push_back(packet_of('0, TYPE_RESET, r.now_time, '0));
        if (q_cnt < capacity()) begin
          q_head = (q_head + DEPTH - 1) % DEPTH;
          q_seq[q_head] = '0;
          q_type[q_head] = TYPE_RESET;
          q_stamp[q_head] = r.now_time;
          q_body[q_head] = '0;
          q_cnt++;
          q_unsent = 1;
        end else begin
          q_unsent = 0;
        end
      end
      CMD_RETRY: if (q_cnt > 0) items.push_back(entry_packet(0));
      CMD_QUERY: begin
        if (q_cnt > 0) begin
          x = blank();
          x.kind = KIND_SPAN;
          x.block_begin = q_seq[slot(0)];
          x.block_end = q_seq[slot(q_cnt - 1)];
          x.block_age = r.now_time - q_stamp[slot(0)];
          items.push_back(x);
        end
      end
      default: ;
    endcase
    if (items.size() == 0) begin
      x = blank();
      x.kind = KIND_STATUS;
      items.push_back(x);
    end
    foreach (items[k]) begin
      items[k].queue_count = q_cnt[10:0];
      items[k].reset_done = q_racked;
      items[k].urgent_flag = q_urgent;
      items[k].last = (k == items.size() - 1);
      sent_q.push_back(items[k]);
    end
    first_pred = items[0];
  endfunction

  task automatic send_req(req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.cmd = r.cmd;
    in_if.msg_type = r.msg_type;
    in_if.payload = r.payload;
    in_if.ack_seq = r.ack_seq;
    in_if.ack_expect = r.ack_expect;
    in_if.now_time = r.now_time;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict(r);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_MAX_ENTRIES: cfg_max = v[10:0];
      REG_URGENT_THR:  cfg_thr = v[10:0];
      default:         cfg_burst = v[6:0];
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (sent_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic req_t mk_req(logic [2:0] c, logic [2:0] t, logic [31:0] b,
                                  logic [31:0] s, logic [31:0] e, logic [31:0] n);
    req_t r;
    r.cmd = c;
    r.msg_type = t;
    r.payload = b;
    r.ack_seq = s;
    r.ack_expect = e;
    r.now_time = n;
    return r;
  endfunction

  function automatic void add_row(req_t r, bit chk, logic [1:0] k, int cnt, bit rd);
    row_t w;
    w.r = r;
    w.chk = chk;
    w.kind = k;
    w.count = cnt[10:0];
    w.rdone = rd;
    rows.push_back(w);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned p, m;
    logic [31:0] hseq;
    r = mk_req(CMD_PUSH, 3'($urandom_range(4)), $urandom, $urandom, 0, 0);
    if ($urandom_range(19) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(3);
    r.now_time = clock_now;
    hseq = (q_cnt > 0) ? q_seq[slot(0)] : q_last_seq;
    p = $urandom_range(99);
    if (p < 34) r.cmd = CMD_PUSH;
    else if (p < 54) r.cmd = CMD_FLUSH;
    else if (p < 76) begin
      r.cmd = CMD_ACK;
      m = $urandom_range(19);
      if (m < 9) begin
        r.ack_expect = 0;
        r.ack_seq = hseq;
        if (q_cnt > 0) r.msg_type = q_type[slot(0)];
      end else if (m < 15) begin
        r.ack_expect = hseq + $urandom_range(4);
        r.ack_seq = hseq + $urandom_range(1);
        r.msg_type = 3'($urandom_range(1));
      end else if (m < 17) begin
        r.ack_seq = hseq + 1;
        r.ack_expect = 0;
      end else if (m == 17) r.msg_type = TYPE_SHUTDOWN;
      else if (m == 18) r.msg_type = TYPE_PING;
      else r.ack_expect = $urandom;
    end
    else if (p < 82) r.cmd = CMD_RESET;
    else if (p < 88) r.cmd = CMD_RETRY;
    else if (p < 96) r.cmd = CMD_QUERY;
    else r.cmd = 3'($urandom_range(7, 6));
    return r;
  endfunction

  // result check
  function automatic void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (sent_q.size() == 0) begin
        $error("result with nothing expected: kind %0h seq_id %0h", out_if.kind,
               out_if.seq_id);
        fails++;
      end else begin
        e = sent_q[0];
        sent_q.delete(0);
        cmp("kind", e.kind, out_if.kind);
        cmp("seq_id", e.seq_id, out_if.seq_id);
        cmp("pkt_type", e.pkt_type, out_if.pkt_type);
        cmp("send_time", e.send_time, out_if.send_time);
        cmp("pkt_payload", e.pkt_payload, out_if.pkt_payload);
        cmp("block_begin", e.block_begin, out_if.block_begin);
        cmp("block_end", e.block_end, out_if.block_end);
        cmp("block_age", e.block_age, out_if.block_age);
        cmp("queue_count", e.queue_count, out_if.queue_count);
        cmp("reset_done", e.reset_done, out_if.reset_done);
        cmp("urgent_flag", e.urgent_flag, out_if.urgent_flag);
        cmp("last", e.last, out_if.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      wd_cnt <= 0;
    else
      wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("reliable_send_retransmit_queue: mismatch");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99) >= snk_stall);
    end
  end

  initial begin
    int unsigned cfgs [5][3];
    int unsigned idles [5][2];
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_PUSH;
    in_if.msg_type = '0;
    in_if.payload = '0;
    in_if.ack_seq = '0;
    in_if.ack_expect = '0;
    in_if.now_time = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fails = 0;
    wd_cnt = 0;
    src_idle = 0;
    snk_stall = 0;
    clock_now = 32'd1000;
    q_head = 0;
    q_cnt = 0;
    q_unsent = 0;
    q_last_seq = '0;
    q_racked = 1'b0;
    q_urgent = 1'b0;
    cfg_max = 1024;
    cfg_thr = 1023;
    cfg_burst = 64;
    cfgs = '{'{1024, 1023, 64}, '{1, 0, 1}, '{4, 2, 0}, '{2047, 1024, 127}, '{0, 2047, 3}};
    idles = '{'{0, 0}, '{51, 0}, '{0, 51}, '{15, 15}, '{0, 0}};

    add_row(mk_req(CMD_QUERY, 0, 0, 0, 0, 0), 1, KIND_STATUS, 0, 0);
    add_row(mk_req(CMD_FLUSH, 0, 0, 0, 0, 0), 1, KIND_STATUS, 0, 0);
    add_row(mk_req(CMD_RETRY, 0, 0, 0, 0, 0), 1, KIND_STATUS, 0, 0);
    add_row(mk_req(CMD_PUSH, 0, 32'hFFFF_FFFF, 0, 0, 0), 1, KIND_STATUS, 1, 0);
    add_row(mk_req(CMD_PUSH, TYPE_SHUTDOWN, 0, 0, 0, 32'hFFFF_FFFF), 1, KIND_STATUS, 2, 0);
    add_row(mk_req(CMD_FLUSH, 0, 0, 0, 0, 1), 1, KIND_STATUS, 2, 0);
    add_row(mk_req(CMD_RESET, 0, 0, 0, 0, 5), 1, KIND_PKT, 3, 0);
    add_row(mk_req(CMD_ACK, TYPE_RESET, 0, 0, 0, 6), 1, KIND_STATUS, 2, 1);
    add_row(mk_req(CMD_FLUSH, 0, 0, 0, 0, 7), 0, 0, 0, 0);
    add_row(mk_req(CMD_QUERY, 0, 0, 0, 0, 100), 0, 0, 0, 0);
    add_row(mk_req(CMD_RETRY, 0, 0, 0, 0, 8), 0, 0, 0, 0);
    add_row(mk_req(CMD_ACK, TYPE_PING, 0, 1, 0, 9), 1, KIND_STATUS, 2, 1);
    add_row(mk_req(3'd6, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9), 1,
            KIND_STATUS, 2, 1);
    add_row(mk_req(3'd7, 0, 0, 0, 0, 9), 1, KIND_STATUS, 2, 1);
    add_row(mk_req(CMD_ACK, 0, 0, 1, 0, 10), 1, KIND_STATUS, 1, 1);
    add_row(mk_req(CMD_ACK, 0, 0, 32'hFFFF_FFFF, 0, 11), 1, KIND_STATUS, 1, 1);
    add_row(mk_req(CMD_PUSH, 1, 32'h1234_5678, 0, 0, 12), 0, 0, 0, 0);
    add_row(mk_req(CMD_FLUSH, 0, 0, 0, 0, 13), 0, 0, 0, 0);
    add_row(mk_req(CMD_ACK, 0, 0, 0, 32'hFFFF_FFFF, 14), 1, KIND_STATUS, 0, 1);
    add_row(mk_req(CMD_ACK, TYPE_SHUTDOWN, 0, 0, 0, 15), 1, KIND_STATUS, 0, 0);
    add_row(mk_req(CMD_ACK, 0, 0, 5, 3, 16), 1, KIND_STATUS, 0, 0);
    add_row(mk_req(CMD_QUERY, 0, 0, 0, 0, 17), 1, KIND_STATUS, 0, 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      send_req(rows[i].r);
      if (rows[i].chk && (first_pred.kind !== rows[i].kind ||
          first_pred.queue_count !== rows[i].count ||
          first_pred.reset_done !== rows[i].rdone)) begin
        $error("row %0d: expected kind %0h count %0d reset_done %0b, got %0h %0d %0b",
               i, rows[i].kind, rows[i].count, rows[i].rdone, first_pred.kind,
               first_pred.queue_count, first_pred.reset_done);
        fails++;
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      reg_write(REG_MAX_ENTRIES, cfgs[ph][0]);
      reg_write(REG_URGENT_THR, cfgs[ph][1]);
      reg_write(REG_BURST_LIMIT, cfgs[ph][2]);
      src_idle = idles[ph][0];
      snk_stall = idles[ph][1];
      send_req(mk_req(CMD_RESET, 0, 0, 0, 0, clock_now));
      send_req(mk_req(CMD_ACK, TYPE_RESET, 0, 0, 0, clock_now));
      repeat (20) send_req(rand_req());
    end

    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait (sent_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (fails == 0)
      $display("reliable_send_retransmit_queue: match");
    else
      $display("reliable_send_retransmit_queue: mismatch");
    $finish;
  end

endmodule
